// ===== rtl/core/disjoint_set_union_table_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef DISJOINT_SET_UNION_TABLE_UNIT_MACROS_SVH
`define DISJOINT_SET_UNION_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dsu assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dsu assertion failed: next-cycle implication");

`endif

// ===== rtl/core/dsu_pkg.sv =====
package dsu_pkg;

    // Fixed field widths
    localparam int NODE_W = 10;
    localparam int ENT_W  = 12;
    localparam int SIZE_W = 11;

    // Entry value of a root whose set holds one node
    localparam logic [ENT_W-1:0] ENT_SINGLE = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_DECIDE,
        ST_LINK_LO,
        ST_LINK_HI,
        ST_DONE
    } dsu_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load;
        logic walk_step;
        logic rec_root;
        logic comp_begin;
        logic comp_step;
        logic start_b;
        logic link_lo;
        logic link_hi;
        logic out_load;
        logic phase_b;
    } dsu_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic rd_root;
        logic start_root;
        logic next_top;
        logic do_merge;
    } dsu_stat_t;

endpackage

// ===== rtl/core/dsu_ctrl.sv =====
module dsu_ctrl
    import dsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dsu_stat_t stat,
    output dsu_cmd_t  cmd
);

    dsu_state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // State, phase and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.phase_b  = phase_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stat.rd_root) begin
                    cmd.rec_root = 1'b1;
                    if (!stat.start_root) begin
                        cmd.comp_begin = 1'b1;
                        state_next     = ST_COMP;
                    end else if (phase_reg) begin
                        state_next = ST_DECIDE;
                    end else begin
                        cmd.start_b = 1'b1;
                        phase_next  = 1'b1;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_COMP: begin
                // Point the visited node at the root, then follow its old parent
                cmd.comp_step = 1'b1;
                if (stat.next_top) begin
                    if (phase_reg) begin
                        state_next = ST_DECIDE;
                    end else begin
                        cmd.start_b = 1'b1;
                        phase_next  = 1'b1;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_DECIDE: begin
                state_next = stat.do_merge ? ST_LINK_LO : ST_DONE;
            end
            ST_LINK_LO: begin
                cmd.link_lo = 1'b1;
                state_next  = ST_LINK_HI;
            end
            ST_LINK_HI: begin
                cmd.link_hi = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/dsu_datapath.sv =====
module dsu_datapath
    import dsu_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dsu_cmd_t          cmd,
    output dsu_stat_t         stat,
    input  logic              s_kind,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,
    output logic [NODE_W-1:0] m_root_of_a,
    output logic              m_same_set,
    output logic [SIZE_W-1:0] m_set_size,
    output logic              m_merged
);

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [31:0] NODE_LIMIT = 32'(NODE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

    logic [ENT_W-1:0] mem [NODE_COUNT];

    logic [ENT_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              kind_reg;
    logic [ADDR_W-1:0] a_reg, b_reg, cur_reg, top_reg;
    logic [ADDR_W-1:0] root_a_reg, root_b_reg;
    logic [ENT_W-1:0]  ent_a_reg, ent_b_reg;
    logic [NODE_W-1:0] out_root_reg;
    logic              out_same_reg, out_merged_reg;
    logic [SIZE_W-1:0] out_size_reg;

    logic [ADDR_W-1:0]        node_a_addr, node_b_addr, parent_addr, start_addr;
    logic [ADDR_W-1:0]        lo_addr, hi_addr, cur_next;
    logic [ADDR_W+NODE_W-1:0] a_wide, b_wide;
    logic [ADDR_W+ENT_W-1:0]  parent_wide, top_ent_wide, lo_ent_wide;
    logic [ADDR_W+NODE_W-1:0] root_out_wide;
    logic [ENT_W-1:0]         sum_ent, size_neg;
    logic                     merge;

    // Map node fields into the table, saturating past the last node
    assign a_wide      = {{ADDR_W{1'b0}}, s_node_a};
    assign b_wide      = {{ADDR_W{1'b0}}, s_node_b};
    assign node_a_addr = (32'(s_node_a) >= NODE_LIMIT) ? LAST_ADDR : a_wide[ADDR_W-1:0];
    assign node_b_addr = (32'(s_node_b) >= NODE_LIMIT) ? LAST_ADDR : b_wide[ADDR_W-1:0];

    assign parent_wide = {{ADDR_W{1'b0}}, rd_data_reg};
    assign parent_addr = parent_wide[ADDR_W-1:0];
    assign start_addr  = cmd.phase_b ? b_reg : a_reg;

    // Link the higher root under the lower one
    assign lo_addr     = (root_a_reg < root_b_reg) ? root_a_reg : root_b_reg;
    assign hi_addr     = (root_a_reg < root_b_reg) ? root_b_reg : root_a_reg;
    assign sum_ent     = ent_a_reg + ent_b_reg;
    assign merge       = !kind_reg && (root_a_reg != root_b_reg);
    assign top_ent_wide = {{ENT_W{1'b0}}, top_reg};
    assign lo_ent_wide  = {{ENT_W{1'b0}}, lo_addr};

    // Walk pointer and read address select
    always_comb begin
        if (cmd.load) begin
            cur_next = node_a_addr;
        end else if (cmd.start_b) begin
            cur_next = b_reg;
        end else if (cmd.comp_begin) begin
            cur_next = start_addr;
        end else if (cmd.walk_step || cmd.comp_step) begin
            cur_next = parent_addr;
        end else begin
            cur_next = cur_reg;
        end
    end
    assign rd_addr = cur_next;

    // Write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = top_ent_wide[ENT_W-1:0];
        if (cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = ENT_SINGLE;
        end else if (cmd.comp_step) begin
            wr_en = 1'b1;
        end else if (cmd.link_lo) begin
            wr_en   = 1'b1;
            wr_addr = lo_addr;
            wr_data = sum_ent;
        end else if (cmd.link_hi) begin
            wr_en   = 1'b1;
            wr_addr = hi_addr;
            wr_data = lo_ent_wide[ENT_W-1:0];
        end
    end

    // Parent table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Item and walk registers
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (cmd.load) begin
            kind_reg <= s_kind;
            a_reg    <= node_a_addr;
            b_reg    <= node_b_addr;
        end
        if (cmd.rec_root) begin
            top_reg <= cur_reg;
            if (cmd.phase_b) begin
                root_b_reg <= cur_reg;
                ent_b_reg  <= rd_data_reg;
            end else begin
                root_a_reg <= cur_reg;
                ent_a_reg  <= rd_data_reg;
            end
        end
    end

    // Result register
    assign size_neg      = merge ? (ENT_W'(0) - sum_ent) : (ENT_W'(0) - ent_a_reg);
    assign root_out_wide = {{NODE_W{1'b0}}, (merge ? lo_addr : root_a_reg)};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_root_reg   <= root_out_wide[NODE_W-1:0];
            out_same_reg   <= merge || (root_a_reg == root_b_reg);
            out_size_reg   <= size_neg[SIZE_W-1:0];
            out_merged_reg <= merge;
        end
    end

    assign m_root_of_a = out_root_reg;
    assign m_same_set  = out_same_reg;
    assign m_set_size  = out_size_reg;
    assign m_merged    = out_merged_reg;

    // Status back to the controller
    assign stat.clr_last   = (clr_cnt_reg == LAST_ADDR);
    assign stat.rd_root    = rd_data_reg[ENT_W-1];
    assign stat.start_root = (cur_reg == start_addr);
    assign stat.next_top   = (parent_addr == top_reg);
    assign stat.do_merge   = merge;

endmodule

// ===== rtl/core/disjoint_set_union_table_unit.sv =====
// Disjoint-set (union-find) table over NODE_COUNT nodes.
// Input channel (s_*): one transaction names node_a, node_b and a kind:
// kind 0 joins the two sets, kind 1 only inspects them. Node indices at or
// past NODE_COUNT saturate to the last node.
// Result channel (m_*): one transaction per input transaction, in order:
// root of node_a, whether both share a set, node_a's set size, and whether
// a union actually joined two sets.
// Flow: items are handled one at a time. Each item walks both find paths
// to their roots, and a real join then writes the lower and the higher
// root in turn before m_valid. Every hop is walked up the parent chain and
// then rewritten toward the root (path compression), both paced by the
// single read and single write port of the parent table. The next item is
// accepted in the cycle after a result is loaded.
// Reset: the table is swept to singleton sets, one entry per cycle, over
// all NODE_COUNT entries after aresetn rises; s_ready stays low meanwhile.
// Stall: a result waits in the output register while m_ready is low; the
// next item may be accepted and worked on, and it holds in its last step
// until the output register frees up.
module disjoint_set_union_table_unit
    import dsu_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [NODE_W-1:0] m_root_of_a,
    output logic              m_same_set,
    output logic [SIZE_W-1:0] m_set_size,
    output logic              m_merged
);

    dsu_cmd_t  cmd;
    dsu_stat_t stat;

    dsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dsu_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_kind      (s_kind),
        .s_node_a    (s_node_a),
        .s_node_b    (s_node_b),
        .m_root_of_a (m_root_of_a),
        .m_same_set  (m_same_set),
        .m_set_size  (m_set_size),
        .m_merged    (m_merged)
    );

endmodule

// ===== rtl/core/dsu_checker.sv =====
`include "disjoint_set_union_table_unit_macros.svh"

module dsu_checker
    import dsu_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [NODE_W-1:0] m_root_of_a,
    input logic              m_same_set,
    input logic [SIZE_W-1:0] m_set_size,
    input logic              m_merged
);

    // Hold a stalled result steady
    `DSU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_root_of_a) && $stable(m_set_size))

    // Take one item at a time
    `DSU_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A real join leaves both nodes in one set
    `DSU_ASSERT_IMPL(a_merge_same, aclk, aresetn, m_valid && m_merged, m_same_set)

    // A joined set holds at least two nodes
    `DSU_ASSERT_IMPL(a_merge_size, aclk, aresetn, m_valid && m_merged, m_set_size >= 11'd2)

    // Set size stays within the node range
    `DSU_ASSERT_IMPL(a_size_range, aclk, aresetn, m_valid,
        (m_set_size != 11'd0) && (m_set_size <= 11'd1024))

endmodule

bind disjoint_set_union_table_unit dsu_checker u_dsu_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import dsu_pkg::*;

    typedef enum logic {
        KIND_UNION = 1'b0,
        KIND_QUERY = 1'b1
    } dsu_kind_t;

    typedef struct {
        dsu_kind_t         kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              drain;
        logic              calm;
    } dsu_item_t;

    typedef struct {
        logic [NODE_W-1:0] root;
        logic              same;
        logic [SIZE_W-1:0] size;
        logic              merged;
    } dsu_answer_t;

    localparam int NODES      = 1024;
    localparam int ITEM_GOAL  = 1150;
    localparam int CALM_ITEMS = 120;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_valid  = 1'b0;
    logic              s_ready;
    logic              s_kind   = 1'b0;
    logic [NODE_W-1:0] s_node_a = '0;
    logic [NODE_W-1:0] s_node_b = '0;
    logic              m_valid;
    logic              m_ready  = 1'b0;
    logic [NODE_W-1:0] m_root_of_a;
    logic              m_same_set;
    logic [SIZE_W-1:0] m_set_size;
    logic              m_merged;

    // Shadow copy of the parent table: parent index, or minus the set size at a root
    logic signed [ENT_W-1:0] shadow_parent [0:NODES-1];

    dsu_item_t   pending_items[$];
    dsu_answer_t expected_answers[$];

    int   items_in     = 0;
    int   results_seen = 0;
    int   errors       = 0;
    int   gap_left     = 0;
    int   gap_rate     = 1;
    int   stall_left   = 0;
    int   stall_rate   = 1;
    logic calm_mode    = 1'b0;

    disjoint_set_union_table_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_node_a    (s_node_a),
        .s_node_b    (s_node_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_root_of_a (m_root_of_a),
        .m_same_set  (m_same_set),
        .m_set_size  (m_set_size),
        .m_merged    (m_merged)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Walk to the root, then point every visited node straight at it
    function automatic int find_root(int node);
        int top;
        int walk;
        int next_hop;
        top = node;
        while (shadow_parent[top] >= 0) top = int'(shadow_parent[top]);
        walk = node;
        while (walk != top) begin
            next_hop = int'(shadow_parent[walk]);
            shadow_parent[walk] = ENT_W'(top);
            walk = next_hop;
        end
        return top;
    endfunction

    // Apply one transaction to the shadow table and return the expected result
    function automatic dsu_answer_t apply_item(dsu_kind_t kind, logic [NODE_W-1:0] na,
                                               logic [NODE_W-1:0] nb);
        int ra;
        int rb;
        int lo;
        int hi;
        int sum;
        dsu_answer_t ans;
        ra = find_root(int'(na));
        rb = find_root(int'(nb));
        ans.merged = 1'b0;
        if (kind == KIND_UNION && ra != rb) begin
            lo = (ra < rb) ? ra : rb;
            hi = (ra < rb) ? rb : ra;
            sum = int'(shadow_parent[lo]) + int'(shadow_parent[hi]);
            shadow_parent[lo] = ENT_W'(sum);
            shadow_parent[hi] = ENT_W'(lo);
            ans.merged = 1'b1;
            ra = lo;
            rb = lo;
        end
        ans.root = NODE_W'(ra);
        ans.same = (ra == rb);
        ans.size = SIZE_W'(-int'(shadow_parent[ra]));
        return ans;
    endfunction

    task automatic queue_item(dsu_kind_t kind, int na, int nb);
        dsu_item_t it;
        it.kind   = kind;
        it.node_a = NODE_W'(na);
        it.node_b = NODE_W'(nb);
        it.drain  = 1'b0;
        it.calm   = 1'b0;
        pending_items = {pending_items, it};
    endtask

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // Driver: present the next pending transaction, hold it until accepted
    always @(posedge aclk) begin
        dsu_item_t   it;
        dsu_answer_t ans;
        logic        taken;
        logic        load;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) begin
                ans = apply_item(dsu_kind_t'(s_kind), s_node_a, s_node_b);
                expected_answers = {expected_answers, ans};
                items_in <= items_in + 1;
            end
            if (!s_valid || taken) begin
                load = 1'b0;
                if ($urandom_range(0, 255) == 0) gap_rate = $urandom_range(0, 3);
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0) begin
                    // hold a draining transaction until every result is back
                    if (!(pending_items[0].drain && (items_in + int'(taken)) != results_seen))
                        load = 1'b1;
                end
                if (load) begin
                    it = pending_items.pop_front();
                    s_kind   <= it.kind;
                    s_node_a <= it.node_a;
                    s_node_b <= it.node_b;
                    if (it.calm) calm_mode <= 1'b1;
                    else if (gap_rate != 0 && $urandom_range(1, 8) <= gap_rate)
                        gap_left = $urandom_range(1, 7);
                end
                s_valid <= load;
            end
        end
    end

    // Monitor: check each result transaction, stall the result channel in bursts
    always @(posedge aclk) begin
        dsu_answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none actual root %0d",
                             $time, m_root_of_a);
                end else begin
                    want = expected_answers.pop_front();
                    check_field("root_of_a", want.root, m_root_of_a);
                    check_field("same_set", want.same, m_same_set);
                    check_field("set_size", want.size, m_set_size);
                    check_field("merged", want.merged, m_merged);
                    results_seen <= results_seen + 1;
                end
            end
            if ($urandom_range(0, 255) == 0) stall_rate = $urandom_range(0, 3);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm_mode && stall_rate != 0 && $urandom_range(1, 8) <= stall_rate) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hard limit on run time
    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int seq;
        int base;
        int span;
        int len;
        int top;
        int na;
        int nb;
        int k;
        int n;

        for (int i = 0; i < NODES; i++) shadow_parent[i] = ENT_SINGLE;

        // Directed: extremes, self unions, repeated unions, a short chain
        queue_item(KIND_QUERY, 0, 0);
        queue_item(KIND_QUERY, 1023, 1023);
        queue_item(KIND_UNION, 0, 1023);
        queue_item(KIND_QUERY, 1023, 0);
        queue_item(KIND_UNION, 1023, 0);
        queue_item(KIND_UNION, 5, 5);
        queue_item(KIND_QUERY, 5, 6);
        queue_item(KIND_UNION, 512, 511);
        queue_item(KIND_QUERY, 511, 512);
        queue_item(KIND_UNION, 1, 2);
        queue_item(KIND_UNION, 2, 1023);
        queue_item(KIND_QUERY, 1023, 2);
        queue_item(KIND_UNION, 682, 341);
        queue_item(KIND_QUERY, 341, 682);
        queue_item(KIND_UNION, 9, 10);
        queue_item(KIND_UNION, 8, 9);
        queue_item(KIND_UNION, 7, 8);
        queue_item(KIND_UNION, 6, 7);
        queue_item(KIND_QUERY, 10, 6);
        queue_item(KIND_QUERY, 10, 0);
        queue_item(KIND_UNION, 10, 1022);
        queue_item(KIND_UNION, 511, 3);
        queue_item(KIND_QUERY, 1022, 511);

        // Random: mostly structured sequences, some noise and broken sequences
        while (pending_items.size() < ITEM_GOAL) begin
            seq = $urandom_range(0, 9);
            if (seq <= 3) begin
                // local cluster of unions and queries
                base = $urandom_range(0, 1023);
                span = $urandom_range(1, 63);
                n = $urandom_range(4, 12);
                for (k = 0; k < n; k++)
                    queue_item(($urandom_range(0, 9) < 7) ? KIND_UNION : KIND_QUERY,
                               base + $urandom_range(0, span), base + $urandom_range(0, span));
            end else if (seq <= 5) begin
                // descending chain, then a query from its far end
                len = $urandom_range(4, 16);
                top = $urandom_range(len + 1, 1023);
                for (k = 0; k < len; k++) queue_item(KIND_UNION, top - k - 1, top - k);
                queue_item(KIND_QUERY, top, top - len);
            end else if (seq == 6) begin
                for (k = 0; k < 4; k++)
                    queue_item(dsu_kind_t'($urandom_range(0, 1)),
                               $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else if (seq == 7) begin
                // self union and a repeated union
                na = $urandom_range(0, 1023);
                nb = $urandom_range(0, 1023);
                queue_item(KIND_UNION, na, na);
                queue_item(KIND_UNION, na, nb);
                queue_item(KIND_UNION, nb, na);
                queue_item(KIND_QUERY, nb, nb);
            end else begin
                // far union joining large sets
                na = $urandom_range(0, 1023);
                nb = $urandom_range(0, 1023);
                queue_item(KIND_UNION, na, nb);
                queue_item(KIND_QUERY, nb, na);
            end
        end

        // No idling at the tail; drain the pipe at a few points
        for (k = pending_items.size() - CALM_ITEMS; k < pending_items.size(); k++)
            pending_items[k].calm = 1'b1;
        pending_items[pending_items.size() / 3].drain = 1'b1;
        pending_items[2 * pending_items.size() / 3].drain = 1'b1;
        pending_items[pending_items.size() - CALM_ITEMS].drain = 1'b1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every transaction to be accepted and answered
        @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || results_seen != items_in)
            @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (errors == 0 && expected_answers.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
